>>> rtl/core/jeq_pkg.sv
// Shared types, codes and sizes of the elimination queue.
package jeq_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 256;
  localparam int unsigned ID_W          = 9;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned STEP_W        = 16;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned NUM_ITEMS_RST = 256;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_CAPTURE = 1'b1;

  localparam logic REG_NUM_ITEMS = 1'b0;

  localparam logic [STAT_W-1:0] ST_CAPTURED = 2'd0;
  localparam logic [STAT_W-1:0] ST_RESTART  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic load;
    logic rotate;
    logic shift;
  } jeq_cell_ctl_t;

endpackage

>>> rtl/core/josephus_elimination_queue.sv
// Round-robin elimination queue: top level with sequencer, register and cell row.
//
// Requests arrive on the in_ channel (valid/ready). A restart request reloads
// the order with ids 1..num_items (capped at MAX_ITEMS); a capture request
// takes step_count, forms r = step_count mod ids left (r = ids left when the
// remainder is zero), rotates r-1 ids to the back and removes the next one.
// Each request gives exactly one result on the out_ channel (valid/ready).
// num_items is to be written over the APB port at address 0 only while the
// block is idle; the block does not enforce this. Restart and capture-on-empty
// go straight to the completion state, which loads the output register; a
// capture first waits for the bit-serial remainder unit, then rotates r-1 ids
// through the cell row, removes the front id and loads the output register.
// One request is worked on at a time, until its result reaches the output register.
// The output register holds a finished result while the receiver stalls; a
// new request is taken meanwhile, and its result waits until the register
// frees. Reset restores num_items = 256 and the order 1..min(256, MAX_ITEMS).
module josephus_elimination_queue import jeq_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [STEP_W-1:0] in_step_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_captured_id,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_ids_left,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned RST_COUNT = (MAX_ITEMS < NUM_ITEMS_RST) ? MAX_ITEMS : NUM_ITEMS_RST;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_ROT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  num_items_r, num_items_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rot_cnt_r, rot_cnt_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [CNT_W-1:0]  res_left_r, res_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0]  out_left_r, out_left_nxt;

  jeq_cell_ctl_t     cell_ctl;
  logic [CNT_W-1:0]  cnt_sat;
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;
  logic              cfg_wr;
  logic              in_acc;
  logic              out_free;
  logic [ID_W-1:0]   cell_id [MAX_ITEMS];

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_NUM_ITEMS);
  assign prdata = (paddr[2] == REG_NUM_ITEMS) ? APB_DW'(num_items_r) : '0;

  always_comb begin
    num_items_nxt = num_items_r;
    if (cfg_wr) begin
      num_items_nxt = pwdata[CNT_W-1:0];
    end
  end

  // cap the load count at the row length
  assign cnt_sat = (32'(num_items_r) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS) : num_items_r;

  // ---- remainder unit ----
  jeq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_step_count),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // ---- cell row: cell 0 is the front ----
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [ID_W-1:0] next_id;
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_id = '0;
    end else begin : g_body
      assign next_id = cell_id[i+1];
    end
    jeq_cell #(.CELL_IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .count    (count_r),
      .next_id  (next_id),
      .front_id (cell_id[0]),
      .id_out   (cell_id[i])
    );
  end

  // ---- sequencer ----
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rot_cnt_nxt   = rot_cnt_r;
    res_id_nxt    = res_id_r;
    res_stat_nxt  = res_stat_r;
    res_left_nxt  = res_left_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_id_nxt    = out_id_r;
    out_stat_nxt  = out_stat_r;
    out_left_nxt  = out_left_r;
    cell_ctl      = '0;
    mod_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_RESTART) begin
            cell_ctl.load = 1'b1;
            count_nxt     = cnt_sat;
            res_id_nxt    = '0;
            res_stat_nxt  = ST_RESTART;
            res_left_nxt  = cnt_sat;
            state_nxt     = S_DONE;
          end else if (count_r == '0) begin
            res_id_nxt   = '0;
            res_stat_nxt = ST_EMPTY;
            res_left_nxt = '0;
            state_nxt    = S_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rot_cnt_nxt = ((mod_rem == '0) ? count_r : mod_rem) - 1'b1;
          state_nxt   = S_ROT;
        end
      end
      S_ROT: begin
        if (rot_cnt_r == '0) begin
          // drop the front id
          cell_ctl.shift = 1'b1;
          res_id_nxt     = cell_id[0];
          res_stat_nxt   = ST_CAPTURED;
          res_left_nxt   = count_r - 1'b1;
          count_nxt      = count_r - 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cell_ctl.rotate = 1'b1;
          rot_cnt_nxt     = rot_cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_stat_nxt  = res_stat_r;
          out_left_nxt  = res_left_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_items_r <= CNT_W'(NUM_ITEMS_RST);
      count_r     <= CNT_W'(RST_COUNT);
      rot_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_items_r <= num_items_nxt;
      count_r     <= count_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_id_r   <= res_id_nxt;
    res_stat_r <= res_stat_nxt;
    res_left_r <= res_left_nxt;
    out_id_r   <= out_id_nxt;
    out_stat_r <= out_stat_nxt;
    out_left_r <= out_left_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_captured_id = out_id_r;
  assign out_status      = out_stat_r;
  assign out_ids_left    = out_left_r;

  // ---- checks ----
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ITEMS)
    else $error("id count beyond row length");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder finished outside its wait state");

  a_capture_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && rot_cnt_r == '0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("capture did not drop one id");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion state");

endmodule

>>> rtl/core/jeq_cell.sv
// One position of the circular id order; moves its id towards the front.
module jeq_cell import jeq_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  jeq_cell_ctl_t   ctl,
  input  logic [CNT_W-1:0] count,
  input  logic [ID_W-1:0] next_id,
  input  logic [ID_W-1:0] front_id,
  output logic [ID_W-1:0] id_out
);

  localparam logic [ID_W-1:0] RST_ID = ID_W'(CELL_IDX + 1);
  localparam int unsigned     POS    = CELL_IDX + 1;

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;
  logic            is_last;

  // the tail of the live order takes the front id on a rotation
  assign is_last = (32'(count) == POS);

  always_comb begin
    id_nxt = id_r;
    if (ctl.load) begin
      id_nxt = RST_ID;
    end else if (ctl.rotate) begin
      id_nxt = is_last ? front_id : next_id;
    end else if (ctl.shift) begin
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= RST_ID;
    end else begin
      id_r <= id_nxt;
    end
  end

  assign id_out = id_r;

endmodule

>>> rtl/core/jeq_mod.sv
// Bit-serial remainder of the step count by the number of ids left.
module jeq_mod import jeq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STEP_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CNT_W-1:0]  rem
);

  localparam int unsigned BCNT_W = $clog2(STEP_W + 1);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [BCNT_W-1:0] bcnt_r,  bcnt_nxt;
  logic [STEP_W-1:0] dvd_r,   dvd_nxt;
  logic [CNT_W:0]    rem_r,   rem_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  div_r,   div_nxt;

  assign trial = {rem_r[CNT_W-1:0], dvd_r[STEP_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bcnt_nxt = bcnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      bcnt_nxt = BCNT_W'(STEP_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // bring down one dividend bit, subtract where it fits
      rem_nxt  = (trial >= {1'b0, div_r}) ? trial - {1'b0, div_r} : trial;
      dvd_nxt  = {dvd_r[STEP_W-2:0], 1'b0};
      bcnt_nxt = bcnt_r - 1'b1;
      if (bcnt_r == BCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bcnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bcnt_r <= bcnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[CNT_W-1:0];

endmodule

>>> verif/jeq_order_checker.sv
// Checker for the elimination queue: follows the id order and compares every result.
`timescale 1ns / 100ps
module jeq_order_checker import jeq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_req_type,
  input  logic [STEP_W-1:0] in_step_count,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ID_W-1:0]   out_captured_id,
  input  logic [STAT_W-1:0] out_status,
  input  logic [CNT_W-1:0]  out_ids_left,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                seen_captured,
  output int                seen_restart,
  output int                seen_empty
);

  localparam int unsigned DEPTH = MAX_ITEMS_DEF;
  localparam logic [APB_AW-1:0] NUM_ITEMS_ADDR = {REG_NUM_ITEMS, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  left;
  } outcome_t;

  logic [ID_W-1:0]  ring [DEPTH];
  int unsigned      ring_head;
  int unsigned      ids_remaining;
  logic [CNT_W-1:0] load_count;
  outcome_t         awaited_results[$];
  int               mismatches;
  int               n_captured, n_restart, n_empty;

  // Reload ids 1..load_count, capped at the ring depth.
  function automatic void refill_ring();
    int unsigned cnt;
    cnt = (load_count > DEPTH) ? DEPTH : load_count;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      ring[i] = (i < cnt) ? ID_W'(i + 1) : '0;
    end
    ring_head     = 0;
    ids_remaining = cnt;
  endfunction

  function automatic outcome_t eliminate_next(input logic req,
                                              input logic [STEP_W-1:0] step);
    int unsigned n;
    int unsigned r;
    outcome_t    o;
    if (req == REQ_RESTART) begin
      refill_ring();
      o.id     = '0;
      o.status = ST_RESTART;
      o.left   = CNT_W'(ids_remaining);
      return o;
    end
    n = ids_remaining;
    if (n == 0) begin
      o.id     = '0;
      o.status = ST_EMPTY;
      o.left   = '0;
      return o;
    end
    r = int'(step) % n;
    if (r == 0) r = n;
    // Move r-1 ids from the front to the back, then drop the front one.
    for (int unsigned i = 1; i < r; i++) begin
      ring[(ring_head + n) % DEPTH] = ring[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
    end
    o.id          = ring[ring_head];
    ring_head     = (ring_head + 1) % DEPTH;
    ids_remaining = n - 1;
    o.status      = ST_CAPTURED;
    o.left        = CNT_W'(ids_remaining);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst_n) begin
      load_count = CNT_W'(NUM_ITEMS_RST);
      refill_ring();
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == NUM_ITEMS_ADDR)
        load_count = pwdata[CNT_W-1:0];
      if (in_valid && in_ready)
        awaited_results.push_back(eliminate_next(in_req_type, in_step_count));
      if (out_valid && out_ready) begin
        got.id     = out_captured_id;
        got.status = out_status;
        got.left   = out_ids_left;
        case (got.status)
          ST_CAPTURED: n_captured++;
          ST_RESTART:  n_restart++;
          default:     n_empty++;
        endcase
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%t: result with no request waiting: id=%0d status=%0d left=%0d",
                     $realtime, got.id, got.status, got.left);
        end else begin
          want = awaited_results.pop_front();
          if (got.id !== want.id || got.status !== want.status || got.left !== want.left)
          begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%t: mismatch: expected id=%0d status=%0d left=%0d, got id=%0d status=%0d left=%0d",
                       $realtime, want.id, want.status, want.left,
                       got.id, got.status, got.left);
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= awaited_results.size();
    seen_captured <= n_captured;
    seen_restart  <= n_restart;
    seen_empty    <= n_empty;
  end

endmodule

>>> verif/testbench.sv
// Top of the elimination queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import jeq_pkg::*;

  localparam logic [APB_AW-1:0] NUM_ITEMS_ADDR  = {REG_NUM_ITEMS, 2'b00};
  localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = {~REG_NUM_ITEMS, 2'b00};
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 1500;
  localparam int END_SETTLE    = 30;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_req_type;
  logic [STEP_W-1:0] in_step_count;
  logic              out_valid;
  logic              out_ready;
  logic [ID_W-1:0]   out_captured_id;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_ids_left;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count, pending, seen_captured, seen_restart, seen_empty;
  int send_idle_pct;
  int stall_pct;
  int hold_gen;

  josephus_elimination_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_step_count(in_step_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_captured_id(out_captured_id), .out_status(out_status),
    .out_ids_left(out_ids_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  jeq_order_checker order_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_step_count(in_step_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_captured_id(out_captured_id), .out_status(out_status),
    .out_ids_left(out_ids_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending),
    .seen_captured(seen_captured), .seen_restart(seen_restart),
    .seen_empty(seen_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a counted hold-off whenever hold_gen moves.
  initial begin : receiver
    int unsigned hold_left;
    int          seen_gen;
    hold_left = 0;
    seen_gen  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_gen != seen_gen) begin
        seen_gen  = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request; hold valid and payload until it is taken.
  task automatic send_request(input logic req, input logic [STEP_W-1:0] step);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_step_count <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(APB_DW - CNT_W)'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned cfg_val;
    int unsigned loaded;
    int unsigned run_len;
    int          issued;
    logic [STEP_W-1:0] step;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_RESTART;
    in_step_count <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct <= 0;
    stall_pct     <= 0;
    hold_gen      <= 0;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full order after reset: zero step and a multiple of the count take the last id.
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'hFFFF);
    send_request(REQ_CAPTURE, 16'h0001);
    send_request(REQ_CAPTURE, 16'h0002);
    send_request(REQ_CAPTURE, 16'h8000);
    send_request(REQ_RESTART, 16'hFFFF);
    send_request(REQ_CAPTURE, 16'h7FFF);
    drain();
    // Single id, then captures on the empty order.
    write_reg(NUM_ITEMS_ADDR, 9'd1);
    send_request(REQ_RESTART, 16'h0000);
    send_request(REQ_CAPTURE, 16'h0009);
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'hFFFF);
    drain();
    // Zero count loads an empty order.
    write_reg(NUM_ITEMS_ADDR, 9'd0);
    send_request(REQ_RESTART, 16'h1234);
    send_request(REQ_CAPTURE, 16'h0001);
    drain();
    // Counts above capacity saturate.
    write_reg(NUM_ITEMS_ADDR, 9'd511);
    send_request(REQ_RESTART, 16'h0000);
    send_request(REQ_CAPTURE, 16'd300);
    drain();
    write_reg(NUM_ITEMS_ADDR, 9'd257);
    send_request(REQ_RESTART, 16'h0000);
    send_request(REQ_CAPTURE, 16'hAAAA);
    send_request(REQ_CAPTURE, 16'h5555);
    drain();
    // A write to an unmapped register must leave the count alone.
    write_reg(UNUSED_REG_ADDR, 9'd2);
    send_request(REQ_RESTART, 16'h0000);
    send_request(REQ_CAPTURE, 16'h0003);
    drain();
    write_reg(NUM_ITEMS_ADDR, 9'd2);
    send_request(REQ_RESTART, 16'h0000);
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'h0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cfg_val = $urandom_range(12, 3);
        1:       cfg_val = 256;
        2:       cfg_val = $urandom_range(120, 13);
        3:       cfg_val = 511;
        4:       cfg_val = $urandom_range(510, 257);
        default: cfg_val = $urandom_range(4, 1);
      endcase
      write_reg(NUM_ITEMS_ADDR, CNT_W'(cfg_val));
      case (ph % 4)
        0:       begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1:       begin send_idle_pct <= 57; stall_pct <= 0;  end
        2:       begin send_idle_pct <= 0;  stall_pct <= 57; end
        default: begin send_idle_pct <= 31; stall_pct <= 31; end
      endcase
      // Long receiver hold while requests keep coming, so the input backs up.
      if (ph == 0) hold_gen <= hold_gen + 1;
      loaded = (cfg_val > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : cfg_val;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        send_request(REQ_RESTART, STEP_W'($urandom()));
        issued++;
        run_len = $urandom_range(loaded + 2, loaded / 2);
        for (int k = 0; k < run_len && issued < PHASE_ITEMS; k++) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: step = STEP_W'($urandom_range(7));
            5, 6, 7:       step = STEP_W'($urandom());
            8:             step = '1;
            default:       step = '0;
          endcase
          // Break the sequence now and then with a restart in mid-run.
          if ($urandom_range(99) < 4) send_request(REQ_RESTART, step);
          else send_request(REQ_CAPTURE, step);
          issued++;
        end
      end
      drain();
    end

    repeat (END_SETTLE) @(posedge clk);
    $display("Covered %0d results: %0d captures, %0d restarts, %0d empty-order errors.",
             seen_captured + seen_restart + seen_empty, seen_captured, seen_restart,
             seen_empty);
    $display("Counts 0, 1, 2, 256, 257, 511 and random, four idling mixes, one long hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/jeq_pkg.sv
rtl/core/jeq_cell.sv
rtl/core/jeq_mod.sv
rtl/core/josephus_elimination_queue.sv
verif/jeq_order_checker.sv
verif/testbench.sv
